// ===== sv/bsr_pkg.sv =====
// Shared constants, codes and types of the banker safety request engine.
package bsr_pkg;

  localparam int PROCESSES   = 8;
  localparam int RESOURCES   = 3;
  localparam int COUNT_WIDTH = 8;

  localparam int PW = (PROCESSES > 2) ? $clog2(PROCESSES) : 1;
  localparam int NW = $clog2(PROCESSES + 1);
  localparam int WW = COUNT_WIDTH + NW;
  localparam int XW = NW + 4;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_AVAIL = 2'd1;
  localparam logic [1:0] CMD_REQ   = 2'd2;
  localparam logic [1:0] CMD_CHECK = 2'd3;

  localparam logic [2:0] ST_STORED      = 3'd0;
  localparam logic [2:0] ST_SAFE        = 3'd1;
  localparam logic [2:0] ST_UNSAFE      = 3'd2;
  localparam logic [2:0] ST_REQ_REFUSED = 3'd3;
  localparam logic [2:0] ST_LOAD_REFUSE = 3'd4;

  localparam logic [3:0] ACT_RESET = 4'd8;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [WW-1:0]          work_t;
  typedef logic [NW-1:0]          pcount_t;
  typedef logic [PW-1:0]          pidx_t;

  typedef struct packed {
    cnt_t [RESOURCES-1:0] max_claim;
    cnt_t [RESOURCES-1:0] alloc;
  } row_t;

  function automatic pcount_t active_count(input logic [3:0] act);
    logic [XW-1:0] a;
    pcount_t       n;
    a = XW'(act);
    if (a == '0) n = NW'(1);
    else if (a > XW'(PROCESSES)) n = NW'(PROCESSES);
    else n = NW'(act);
    return n;
  endfunction

endpackage

// ===== sv/bsr_channels.sv =====
// Handshake channel interfaces: request input, result output, configuration write.
interface bsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [2:0] process;
  logic [7:0] amount_a;
  logic [7:0] amount_b;
  logic [7:0] amount_c;
  logic [7:0] limit_a;
  logic [7:0] limit_b;
  logic [7:0] limit_c;
  modport source (output valid, cmd, process, amount_a, amount_b, amount_c,
                  limit_a, limit_b, limit_c, input ready);
  modport sink (input valid, cmd, process, amount_a, amount_b, amount_c,
                limit_a, limit_b, limit_c, output ready);
endinterface

interface bsr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] seq_process;
  logic       last;
  modport source (output valid, status, seq_process, last, input ready);
  modport sink (input valid, status, seq_process, last, output ready);
endinterface

interface bsr_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/banker_safety_request_engine.sv =====
// Top level: banker's algorithm engine with row memory and safety scan.
//
//   channel  dir  beat carries
//   in_if    in   cmd, process, amount_a/b/c, limit_a/b/c
//   out_if   out  status, seq_process, last
//   cfg_if   in   active process count (4 bits)
//
// Load and set-available: result registered at the beat.
// Request: registered row read, checked in S_RCHK, then the safety scan.
// Safety scan: one row per cycle through the row memory read port,
//   up to n passes of n rows (n = active count), then n result beats if safe, else one.
// Reset is synchronous; all tables read as zero until written.
// A stalled output holds the engine; input is taken only when idle.
module banker_safety_request_engine import bsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bsr_in_if.sink    in_if,
  bsr_out_if.source out_if,
  bsr_cfg_if.sink   cfg_if
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RCHK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RESP = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [3:0] act_r;
  pcount_t    n;

  cnt_t  avail_r [RESOURCES];
  cnt_t  avail_nxt [RESOURCES];

  row_t  mem [PROCESSES];
  logic [PROCESSES-1:0] row_valid_r;
  pidx_t rd_addr;
  row_t  rd_data_r;
  logic  rd_valid_r;
  row_t  row_q;
  logic  mem_we;
  pidx_t mem_wa;
  row_t  mem_wd;

  logic  req_mode_r, req_mode_nxt;
  pidx_t req_p_r, req_p_nxt;
  cnt_t  amt_r [RESOURCES];
  cnt_t  amt_nxt [RESOURCES];
  cnt_t  max_r [RESOURCES];
  cnt_t  max_nxt [RESOURCES];
  cnt_t  trial_r [RESOURCES];
  cnt_t  trial_nxt [RESOURCES];

  work_t work_r [RESOURCES];
  work_t work_nxt [RESOURCES];
  logic [PROCESSES-1:0] done_r, done_nxt;
  pcount_t cnt_r, cnt_nxt;
  logic  prog_r, prog_nxt;
  pidx_t scan_idx_r, scan_idx_nxt;
  pidx_t seq_r [PROCESSES];
  pidx_t seq_nxt [PROCESSES];
  pidx_t emit_idx_r, emit_idx_nxt;
  logic [2:0] resp_status_r, resp_status_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic [2:0] out_seq_r, out_seq_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_load;
  logic       out_free;
  logic       accept;

  cnt_t  in_amt [RESOURCES];
  cnt_t  in_lim [RESOURCES];
  logic [XW-1:0] proc_x;

  cnt_t  row_alloc [RESOURCES];
  logic  fits;
  logic  last_row;
  pcount_t cnt_new;
  logic  prog_new;

  assign n        = active_count(act_r);
  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready  = (state_r == S_IDLE) && out_free;
  assign accept   = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.seq_process = out_seq_r;
  assign out_if.last        = out_last_r;

  assign in_amt[0] = COUNT_WIDTH'(in_if.amount_a);
  assign in_amt[1] = COUNT_WIDTH'(in_if.amount_b);
  assign in_amt[2] = COUNT_WIDTH'(in_if.amount_c);
  assign in_lim[0] = COUNT_WIDTH'(in_if.limit_a);
  assign in_lim[1] = COUNT_WIDTH'(in_if.limit_b);
  assign in_lim[2] = COUNT_WIDTH'(in_if.limit_c);
  assign proc_x    = XW'(in_if.process);

  assign row_q = rd_valid_r ? rd_data_r : '0;

  // row under evaluation, with the trial grant forwarded onto the requester
  always_comb begin
    logic ok;
    ok = !done_r[scan_idx_r];
    for (int r = 0; r < RESOURCES; r++) begin
      row_alloc[r] = (req_mode_r && scan_idx_r == req_p_r) ? trial_r[r] : row_q.alloc[r];
      if (WW'(row_q.max_claim[r] - row_alloc[r]) > work_r[r]) ok = 1'b0;
    end
    fits     = ok;
    last_row = (NW'(scan_idx_r) + NW'(1)) == n;
    cnt_new  = cnt_r + NW'(fits);
    prog_new = prog_r | fits;
  end

  always_comb begin
    logic ok;
    state_nxt       = state_r;
    req_mode_nxt    = req_mode_r;
    req_p_nxt       = req_p_r;
    done_nxt        = done_r;
    cnt_nxt         = cnt_r;
    prog_nxt        = prog_r;
    scan_idx_nxt    = scan_idx_r;
    emit_idx_nxt    = emit_idx_r;
    resp_status_nxt = resp_status_r;
    out_load        = 1'b0;
    out_status_nxt  = out_status_r;
    out_seq_nxt     = out_seq_r;
    out_last_nxt    = out_last_r;
    rd_addr         = '0;
    mem_we          = 1'b0;
    mem_wa          = req_p_r;
    mem_wd          = '0;
    ok              = 1'b1;
    for (int r = 0; r < RESOURCES; r++) begin
      avail_nxt[r] = avail_r[r];
      amt_nxt[r]   = amt_r[r];
      max_nxt[r]   = max_r[r];
      trial_nxt[r] = trial_r[r];
      work_nxt[r]  = work_r[r];
    end
    for (int p = 0; p < PROCESSES; p++) seq_nxt[p] = seq_r[p];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_if.cmd)
            CMD_LOAD: begin
              if (proc_x >= XW'(PROCESSES)) ok = 1'b0;
              for (int r = 0; r < RESOURCES; r++)
                if (in_amt[r] > in_lim[r]) ok = 1'b0;
              mem_we = ok;
              mem_wa = PW'(in_if.process);
              for (int r = 0; r < RESOURCES; r++) begin
                mem_wd.max_claim[r] = in_lim[r];
                mem_wd.alloc[r]     = in_amt[r];
              end
              out_load       = 1'b1;
              out_status_nxt = ok ? ST_STORED : ST_LOAD_REFUSE;
              out_seq_nxt    = '0;
              out_last_nxt   = 1'b1;
            end
            CMD_AVAIL: begin
              for (int r = 0; r < RESOURCES; r++) avail_nxt[r] = in_amt[r];
              out_load       = 1'b1;
              out_status_nxt = ST_STORED;
              out_seq_nxt    = '0;
              out_last_nxt   = 1'b1;
            end
            CMD_REQ: begin
              if (proc_x >= XW'(n)) begin
                out_load       = 1'b1;
                out_status_nxt = ST_REQ_REFUSED;
                out_seq_nxt    = '0;
                out_last_nxt   = 1'b1;
              end else begin
                rd_addr      = PW'(in_if.process);
                req_p_nxt    = PW'(in_if.process);
                req_mode_nxt = 1'b1;
                for (int r = 0; r < RESOURCES; r++) amt_nxt[r] = in_amt[r];
                state_nxt    = S_RCHK;
              end
            end
            default: begin
              req_mode_nxt = 1'b0;
              for (int r = 0; r < RESOURCES; r++) work_nxt[r] = WW'(avail_r[r]);
              done_nxt     = '0;
              cnt_nxt      = '0;
              prog_nxt     = 1'b0;
              scan_idx_nxt = '0;
              state_nxt    = S_SCAN;
            end
          endcase
        end
      end
      S_RCHK: begin
        for (int r = 0; r < RESOURCES; r++)
          if (amt_r[r] > avail_r[r] || amt_r[r] > row_q.max_claim[r] - row_q.alloc[r])
            ok = 1'b0;
        if (!ok) begin
          req_mode_nxt    = 1'b0;
          resp_status_nxt = ST_REQ_REFUSED;
          state_nxt       = S_RESP;
        end else begin
          for (int r = 0; r < RESOURCES; r++) begin
            trial_nxt[r] = row_q.alloc[r] + amt_r[r];
            max_nxt[r]   = row_q.max_claim[r];
            work_nxt[r]  = WW'(avail_r[r] - amt_r[r]);
          end
          done_nxt     = '0;
          cnt_nxt      = '0;
          prog_nxt     = 1'b0;
          scan_idx_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = last_row ? '0 : scan_idx_r + PW'(1);
        if (fits) begin
          for (int r = 0; r < RESOURCES; r++) work_nxt[r] = work_r[r] + WW'(row_alloc[r]);
          done_nxt[scan_idx_r]       = 1'b1;
          seq_nxt[cnt_r[PW-1:0]]     = scan_idx_r;
        end
        cnt_nxt      = cnt_new;
        prog_nxt     = prog_new;
        scan_idx_nxt = last_row ? '0 : scan_idx_r + PW'(1);
        if (last_row) begin
          prog_nxt = 1'b0;
          if (cnt_new == n) begin
            if (req_mode_r) begin
              mem_we = 1'b1;
              mem_wa = req_p_r;
              for (int r = 0; r < RESOURCES; r++) begin
                mem_wd.max_claim[r] = max_r[r];
                mem_wd.alloc[r]     = trial_r[r];
                avail_nxt[r]        = avail_r[r] - amt_r[r];
              end
            end
            emit_idx_nxt = '0;
            state_nxt    = S_EMIT;
          end else if (!prog_new) begin
            resp_status_nxt = ST_UNSAFE;
            state_nxt       = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = resp_status_r;
          out_seq_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = ST_SAFE;
          out_seq_nxt    = 3'(seq_r[emit_idx_r]);
          out_last_nxt   = (NW'(emit_idx_r) + NW'(1)) == n;
          emit_idx_nxt   = emit_idx_r + PW'(1);
          if (out_last_nxt) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load) out_valid_nxt = 1'b1;
    else if (out_if.ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // row memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= ACT_RESET;
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      req_mode_r  <= 1'b0;
      for (int r = 0; r < RESOURCES; r++) avail_r[r] <= '0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_if.valid && cfg_if.ready) act_r <= cfg_if.data;
      if (mem_we) row_valid_r[mem_wa] <= 1'b1;
      rd_valid_r  <= row_valid_r[rd_addr];
      out_valid_r <= out_valid_nxt;
      req_mode_r  <= req_mode_nxt;
      for (int r = 0; r < RESOURCES; r++) avail_r[r] <= avail_nxt[r];
    end
  end

  always_ff @(posedge clk) begin
    req_p_r       <= req_p_nxt;
    done_r        <= done_nxt;
    cnt_r         <= cnt_nxt;
    prog_r        <= prog_nxt;
    scan_idx_r    <= scan_idx_nxt;
    emit_idx_r    <= emit_idx_nxt;
    resp_status_r <= resp_status_nxt;
    out_status_r  <= out_status_nxt;
    out_seq_r     <= out_seq_nxt;
    out_last_r    <= out_last_nxt;
    for (int r = 0; r < RESOURCES; r++) begin
      amt_r[r]   <= amt_nxt[r];
      max_r[r]   <= max_nxt[r];
      trial_r[r] <= trial_nxt[r];
      work_r[r]  <= work_nxt[r];
    end
    for (int p = 0; p < PROCESSES; p++) seq_r[p] <= seq_nxt[p];
  end

  a_commit_only_req: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_SCAN) |-> req_mode_r)
    else $error("row commit outside a request");

  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ($countones(done_r) == int'(cnt_r)))
    else $error("finished count disagrees with done bits");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_EMIT) |-> (cnt_r <= n))
    else $error("finished count above active count");

  a_trial_claim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && req_mode_r) |->
      (trial_r[0] <= max_r[0] && trial_r[1] <= max_r[1] && trial_r[2] <= max_r[2]))
    else $error("trial allocation above claim");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_load && out_last_nxt) |=> (state_r == S_IDLE))
    else $error("sequence did not end on last beat");

endmodule

// ===== tb/bsr_checker.sv =====
// Checker: watches the banker engine channels, predicts each result beat and compares.
`timescale 1ns / 100ps

module bsr_checker import bsr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bsr_in_if    in_if,
  bsr_out_if   out_if,
  bsr_cfg_if   cfg_if,
  output int   mismatches,
  output int   owed,
  output int   beats_in,
  output int   beats_out,
  output int   safe_runs,
  output int   turned_down
);

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] seq_process;
    logic       last;
  } verdict_t;

  cnt_t       claim_tbl [PROCESSES][RESOURCES];
  cnt_t       alloc_tbl [PROCESSES][RESOURCES];
  cnt_t       avail_vec [RESOURCES];
  logic [3:0] act_reg;
  verdict_t   verdict_q [$];

  logic [1:0] op;
  logic [2:0] row;
  cnt_t       amt [RESOURCES];
  cnt_t       lim [RESOURCES];
  cnt_t       room;
  bit         refuse;
  verdict_t   want;

  function automatic int live_rows();
    if (act_reg == 4'd0) return 1;
    if (int'(act_reg) > PROCESSES) return PROCESSES;
    return int'(act_reg);
  endfunction

  function automatic void owe(input logic [2:0] status, input logic [2:0] seq_p,
                              input logic last);
    verdict_t v;
    v.status      = status;
    v.seq_process = seq_p;
    v.last        = last;
    verdict_q.push_back(v);
  endfunction

  // Scan active rows pass after pass; queue the safe order or one unsafe beat.
  function automatic bit scan_safe_order();
    logic [15:0] work [RESOURCES];
    bit          finished [PROCESSES];
    int          order [$];
    int          n;
    bit          moved;
    bit          fits;
    cnt_t        need;
    n = live_rows();
    for (int r = 0; r < RESOURCES; r++) work[r] = 16'(avail_vec[r]);
    for (int p = 0; p < PROCESSES; p++) finished[p] = 1'b0;
    while (order.size() < n) begin
      moved = 1'b0;
      for (int p = 0; p < n; p++) begin
        if (!finished[p]) begin
          fits = 1'b1;
          for (int r = 0; r < RESOURCES; r++) begin
            need = claim_tbl[p][r] - alloc_tbl[p][r];
            if (16'(need) > work[r]) fits = 1'b0;
          end
          if (fits) begin
            for (int r = 0; r < RESOURCES; r++) work[r] += 16'(alloc_tbl[p][r]);
            order.push_back(p);
            finished[p] = 1'b1;
            moved = 1'b1;
          end
        end
      end
      if (!moved) begin
        owe(ST_UNSAFE, 3'd0, 1'b1);
        return 1'b0;
      end
    end
    for (int k = 0; k < n; k++) owe(ST_SAFE, 3'(order[k]), k == n - 1);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PROCESSES; p++) begin
        for (int r = 0; r < RESOURCES; r++) begin
          claim_tbl[p][r] = '0;
          alloc_tbl[p][r] = '0;
        end
      end
      for (int r = 0; r < RESOURCES; r++) avail_vec[r] = '0;
      act_reg = ACT_RESET;
      verdict_q.delete();
      mismatches  = 0;
      beats_in    = 0;
      beats_out   = 0;
      safe_runs   = 0;
      turned_down = 0;
    end else begin
      // result beats belong to earlier commands, so compare before predicting
      if (out_if.valid && out_if.ready) begin
        beats_out++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat status=%0d seq=%0d last=%0d with nothing owed",
                   $time, out_if.status, out_if.seq_process, out_if.last);
        end else begin
          want = verdict_q.pop_front();
          if (out_if.status !== want.status || out_if.seq_process !== want.seq_process ||
              out_if.last !== want.last) begin
            mismatches++;
            $display("%0t: result mismatch, expected status=%0d seq=%0d last=%0d, got status=%0d seq=%0d last=%0d",
                     $time, want.status, want.seq_process, want.last,
                     out_if.status, out_if.seq_process, out_if.last);
          end
        end
      end

      if (cfg_if.valid && cfg_if.ready) act_reg = cfg_if.data;

      if (in_if.valid && in_if.ready) begin
        beats_in++;
        op     = in_if.cmd;
        row    = in_if.process;
        amt[0] = in_if.amount_a;
        amt[1] = in_if.amount_b;
        amt[2] = in_if.amount_c;
        lim[0] = in_if.limit_a;
        lim[1] = in_if.limit_b;
        lim[2] = in_if.limit_c;
        case (op)
          CMD_LOAD: begin
            refuse = int'(row) >= PROCESSES;
            for (int r = 0; r < RESOURCES; r++) if (amt[r] > lim[r]) refuse = 1'b1;
            if (refuse) begin
              owe(ST_LOAD_REFUSE, 3'd0, 1'b1);
            end else begin
              for (int r = 0; r < RESOURCES; r++) begin
                alloc_tbl[row][r] = amt[r];
                claim_tbl[row][r] = lim[r];
              end
              owe(ST_STORED, 3'd0, 1'b1);
            end
          end
          CMD_AVAIL: begin
            for (int r = 0; r < RESOURCES; r++) avail_vec[r] = amt[r];
            owe(ST_STORED, 3'd0, 1'b1);
          end
          CMD_REQ: begin
            refuse = int'(row) >= live_rows();
            if (!refuse) begin
              for (int r = 0; r < RESOURCES; r++) begin
                room = claim_tbl[row][r] - alloc_tbl[row][r];
                if (amt[r] > avail_vec[r] || amt[r] > room) refuse = 1'b1;
              end
            end
            if (refuse) begin
              owe(ST_REQ_REFUSED, 3'd0, 1'b1);
              turned_down++;
            end else begin
              for (int r = 0; r < RESOURCES; r++) begin
                avail_vec[r]      -= amt[r];
                alloc_tbl[row][r] += amt[r];
              end
              if (scan_safe_order()) begin
                safe_runs++;
              end else begin
                // trial grant leaves the system unsafe: undo it
                for (int r = 0; r < RESOURCES; r++) begin
                  avail_vec[r]      += amt[r];
                  alloc_tbl[row][r] -= amt[r];
                end
                turned_down++;
              end
            end
          end
          default: begin
            if (scan_safe_order()) safe_runs++;
          end
        endcase
      end
      owed = verdict_q.size();
    end
  end

endmodule

// ===== tb/tb_banker_safety_request_engine.sv =====
// Testbench top: drives commands and active-count writes, gives the verdict.
`timescale 1ns / 100ps

module tb_banker_safety_request_engine;
  import bsr_pkg::*;

  localparam int LIMIT = 200000;

  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_EVERY_THIRD} rdy_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  bsr_in_if  in_if ();
  bsr_out_if out_if ();
  bsr_cfg_if cfg_if ();

  int mismatches, owed, beats_in, beats_out, safe_runs, turned_down;
  int burst_left;
  int cycles;
  int settings_used;
  int stall_tick;
  rdy_mode_t rdy_mode;

  banker_safety_request_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  bsr_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_if      (cfg_if),
    .mismatches  (mismatches),
    .owed        (owed),
    .beats_in    (beats_in),
    .beats_out   (beats_out),
    .safe_runs   (safe_runs),
    .turned_down (turned_down)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d result beats still owed", cycles, owed);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern, in one of four randomly chosen modes
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
    case (rdy_mode)
      RDY_ALWAYS:  out_if.ready <= 1'b1;
      RDY_MOSTLY:  out_if.ready <= ($urandom_range(0, 3) != 0);
      RDY_RARELY:  out_if.ready <= ($urandom_range(0, 3) == 0);
      default:     out_if.ready <= (stall_tick % 3 != 0);
    endcase
  end

  function automatic logic [7:0] rand_count();
    case ($urandom_range(0, 9))
      0:       return 8'hFF;
      1:       return 8'h00;
      2:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, 12));
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] cmd, input logic [2:0] row,
                           input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                           input logic [7:0] la, input logic [7:0] lb, input logic [7:0] lc);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_if.valid    <= 1'b1;
    in_if.cmd      <= cmd;
    in_if.process  <= row;
    in_if.amount_a <= a;
    in_if.amount_b <= b;
    in_if.amount_c <= c;
    in_if.limit_a  <= la;
    in_if.limit_b  <= lb;
    in_if.limit_c  <= lc;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (owed != 0) @(negedge clk);
  endtask

  task automatic write_active(input logic [3:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // well-formed setup of the active rows, then a random command mix
  task automatic random_phase(input logic [3:0] act, input int mix_beats);
    int          rows;
    logic [7:0]  claim [3];
    logic [7:0]  held [3];
    logic [7:0]  amt [3];
    int          pick;
    logic [2:0]  row;
    rows = (act == 4'd0) ? 1 : ((int'(act) > PROCESSES) ? PROCESSES : int'(act));
    write_active(act);
    for (int p = 0; p < rows; p++) begin
      for (int r = 0; r < 3; r++) begin
        claim[r] = rand_count();
        held[r]  = 8'($urandom_range(0, claim[r]));
      end
      send_beat(CMD_LOAD, 3'(p), held[0], held[1], held[2], claim[0], claim[1], claim[2]);
    end
    send_beat(CMD_AVAIL, 3'($urandom), 8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
              8'($urandom_range(0, 20)), 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < mix_beats; i++) begin
      pick = $urandom_range(0, 99);
      row  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(0, rows - 1));
      if (pick < 18) begin
        for (int r = 0; r < 3; r++) begin
          claim[r] = rand_count();
          held[r]  = ($urandom_range(0, 6) == 0) ? rand_count()
                                                 : 8'($urandom_range(0, claim[r]));
        end
        send_beat(CMD_LOAD, 3'($urandom_range(0, 7)), held[0], held[1], held[2],
                  claim[0], claim[1], claim[2]);
      end else if (pick < 28) begin
        for (int r = 0; r < 3; r++)
          amt[r] = ($urandom_range(0, 3) == 0) ? rand_count() : 8'($urandom_range(0, 20));
        send_beat(CMD_AVAIL, 3'($urandom), amt[0], amt[1], amt[2],
                  8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 72) begin
        for (int r = 0; r < 3; r++)
          amt[r] = ($urandom_range(0, 6) == 0) ? rand_count() : 8'($urandom_range(0, 3));
        send_beat(CMD_REQ, row, amt[0], amt[1], amt[2],
                  8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_beat(CMD_CHECK, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.cmd      = CMD_LOAD;
    in_if.process  = '0;
    in_if.amount_a = '0;
    in_if.amount_b = '0;
    in_if.amount_c = '0;
    in_if.limit_a  = '0;
    in_if.limit_b  = '0;
    in_if.limit_c  = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    rdy_mode       = RDY_ALWAYS;
    burst_left     = 0;
    cycles         = 0;
    settings_used  = 0;
    stall_tick     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-zero tables, refused loads, reordered safe sequence,
    // rollback, unsafe check, need and available refusals, wide work sums
    send_beat(CMD_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_LOAD,  3'd0, 8'd5, 8'd0, 8'd0, 8'd4, 8'd9, 8'd9);
    send_beat(CMD_LOAD,  3'd0, 8'd0, 8'd0, 8'd9, 8'd9, 8'd9, 8'd8);
    send_beat(CMD_LOAD,  3'd0, 8'd0, 8'd0, 8'd0, 8'd10, 8'd10, 8'd10);
    send_beat(CMD_LOAD,  3'd1, 8'd0, 8'd0, 8'd0, 8'd10, 8'd10, 8'd10);
    send_beat(CMD_AVAIL, 3'd0, 8'd10, 8'd10, 8'd10, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_REQ,   3'd1, 8'd5, 8'd5, 8'd5, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_REQ,   3'd0, 8'd5, 8'd5, 8'd5, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_REQ,   3'd0, 8'd6, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_AVAIL, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_AVAIL, 3'd0, 8'd200, 8'd200, 8'd200, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_REQ,   3'd1, 8'd6, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_REQ,   3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_LOAD,  3'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_LOAD,  3'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_LOAD,  3'd7, 8'd0, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_AVAIL, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_REQ,   3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_CHECK, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    write_active(4'd2);
    send_beat(CMD_REQ,   3'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    write_active(4'd0);
    send_beat(CMD_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_REQ,   3'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    write_active(4'd15);
    send_beat(CMD_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

    random_phase(4'd3, 10);
    random_phase(4'd8, 10);
    random_phase(4'd1, 10);
    random_phase(4'd15, 10);
    random_phase(4'd0, 7);
    random_phase(4'($urandom_range(1, 15)), 10);

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d command beats and %0d result beats over %0d active-count settings;",
             beats_in, beats_out, settings_used);
    $display("%0d commands ended in a safe sequence, %0d requests refused or rolled back.",
             safe_runs, turned_down);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bsr_pkg.sv
sv/bsr_channels.sv
sv/banker_safety_request_engine.sv
tb/bsr_checker.sv
tb/tb_banker_safety_request_engine.sv
